// ===== sv/dbl_pkg.sv =====
// shared types and constants for the depth bin light range builder
package dbl_pkg;

  localparam int BIN_RANGE_W = 15;
  localparam int IDX_W = 16;
  localparam int MULT_W = 32;
  localparam logic [15:0] MARKER_RESET = 16'd257;

  typedef struct packed {
    logic signed [23:0] depth_near;
    logic signed [23:0] depth_far;
    logic               final_light;
  } item_t;

  typedef struct packed {
    logic [5:0]  bin_number;
    logic [15:0] first_light;
    logic [15:0] last_light_index;
    logic        overflow;
    logic        bin_final;
  } result_t;

  typedef struct packed {
    logic                   hit_en;
    logic [BIN_RANGE_W-1:0] lo;
    logic [BIN_RANGE_W-1:0] hi;
    logic [IDX_W-1:0]       idx;
  } update_t;

endpackage

// ===== sv/dbl_cell.sv =====
// one bin cell: running first and last light index, shifts toward the output
module dbl_cell #(
  parameter int BIN_ID = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dbl_pkg::update_t      upd,
  input  logic                  shift,
  input  logic [15:0]           next_first,
  input  logic [15:0]           next_last,
  output logic [15:0]           first,
  output logic [15:0]           last
);

  localparam logic [dbl_pkg::BIN_RANGE_W-1:0] ID = dbl_pkg::BIN_RANGE_W'(BIN_ID);

  logic hit;

  assign hit = upd.hit_en && (ID >= upd.lo) && (ID <= upd.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= dbl_pkg::MARKER_RESET;
      last  <= '0;
    end else if (shift) begin
      first <= next_first;
      last  <= next_last;
    end else if (hit) begin
      if (upd.idx < first) first <= upd.idx;
      if (upd.idx > last) last <= upd.idx;
    end
  end

endmodule

// ===== sv/dbl_front.sv =====
// input stage: depth to bin range, light index counter and overflow flag
module dbl_front #(
  parameter int NUM_BINS = 64,
  parameter int MAX_LIGHTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dbl_pkg::item_t        item,
  input  logic                  frame_done,
  output dbl_pkg::update_t      upd,
  output logic                  upd_final,
  output logic                  overflow_flag
);

  localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LIGHTS);
  localparam logic signed [dbl_pkg::MULT_W-1:0] NB = dbl_pkg::MULT_W'(NUM_BINS);
  localparam logic signed [dbl_pkg::MULT_W-1:0] ROUND_UP = dbl_pkg::MULT_W'(65535);

  logic [CNT_W-1:0]                  light_counter;
  logic signed [dbl_pkg::MULT_W-1:0] near_ext, far_ext, prod_near, prod_far;
  logic [dbl_pkg::BIN_RANGE_W-1:0]   lo_next, hi_next;
  logic                              room, skip;

  assign near_ext  = {{(dbl_pkg::MULT_W-24){item.depth_near[23]}}, item.depth_near};
  assign far_ext   = {{(dbl_pkg::MULT_W-24){item.depth_far[23]}}, item.depth_far};
  assign prod_near = near_ext * NB;
  assign prod_far  = far_ext * NB + ROUND_UP;
  assign lo_next   = (item.depth_near <= 0) ? '0 : prod_near[30:16];
  assign hi_next   = (item.depth_far <= 0) ? '0 : prod_far[30:16];
  assign room      = light_counter < MAX_CNT;
  assign skip      = item.depth_near[23] && item.depth_far[23];

  always_ff @(posedge clk) begin
    if (rst) begin
      light_counter <= '0;
      overflow_flag <= 1'b0;
      upd.hit_en    <= 1'b0;
      upd_final     <= 1'b0;
    end else begin
      upd.hit_en <= accept && room && !skip;
      upd_final  <= accept && item.final_light;
      if (accept) begin
        upd.lo  <= lo_next;
        upd.hi  <= hi_next;
        upd.idx <= dbl_pkg::IDX_W'(light_counter);
      end
      if (frame_done) begin
        light_counter <= '0;
        overflow_flag <= 1'b0;
      end else if (accept) begin
        if (room) light_counter <= light_counter + 1'b1;
        else overflow_flag <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/depth_bin_light_range_builder_top.sv =====
// top level of the depth bin light range builder
// Usage: lights come in depth order, one transfer per cycle while busy is low,
// start high with the light on item. Each light gets the next index in arrival
// order; the front stage turns its near and far depth into a bin range and the
// row of NUM_BINS bin cells updates first and last index in the next cycle.
// A light marked final_light closes the frame: busy goes high; once upd_final and
// then out_active are registered, the cell row shifts toward the output, one bin per
// cycle, so NUM_BINS results with strobe high follow back to back, bin 0
// first, bin_final set on the last. The shift pulls the empty marker and zero
// into the row, so the store is clear when busy drops again.
// Throughput: one light per cycle within a frame; at the end of a frame busy
// stays high while upd_final is set and while the cell chain shifts out.
// cfg_we writes the empty marker; it is used at the next clear of the row.
// Reset sets marker to 257, all bins empty, counter and overflow to zero.
// Results are shown for one cycle only; the receiver cannot stall them.
module depth_bin_light_range_builder_top #(
  parameter int NUM_BINS = 64,
  parameter int MAX_LIGHTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dbl_pkg::item_t    item,
  output logic              strobe,
  output dbl_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  dbl_pkg::update_t upd;
  logic             upd_final, overflow_flag, accept;
  logic             out_active, out_overflow;
  logic [BIN_W-1:0] out_count;
  logic [15:0]      marker;
  logic [15:0]      first_chain [NUM_BINS+1];
  logic [15:0]      last_chain [NUM_BINS+1];

  assign accept = start && !busy;
  assign busy   = upd_final || out_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= dbl_pkg::MARKER_RESET;
    end else if (cfg_we) begin
      marker <= cfg_data;
    end
  end

  dbl_front #(
    .NUM_BINS   (NUM_BINS),
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .frame_done    (upd_final),
    .upd           (upd),
    .upd_final     (upd_final),
    .overflow_flag (overflow_flag)
  );

  assign first_chain[NUM_BINS] = marker;
  assign last_chain[NUM_BINS]  = '0;

  for (genvar b = 0; b < NUM_BINS; b++) begin : g_cell
    dbl_cell #(
      .BIN_ID (b)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .upd        (upd),
      .shift      (out_active),
      .next_first (first_chain[b+1]),
      .next_last  (last_chain[b+1]),
      .first      (first_chain[b]),
      .last       (last_chain[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_active <= 1'b0;
      out_count  <= '0;
    end else if (upd_final) begin
      out_active <= 1'b1;
      out_count  <= '0;
    end else if (out_active) begin
      out_count <= out_count + 1'b1;
      if (out_count == LAST_BIN) out_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_final) out_overflow <= overflow_flag;
  end

  assign strobe                  = out_active;
  assign result.bin_number       = 6'(out_count);
  assign result.first_light      = first_chain[0];
  assign result.last_light_index = last_chain[0];
  assign result.overflow         = out_overflow;
  assign result.bin_final        = out_count == LAST_BIN;

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result transfer while not busy");

  a_end_of_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && result.bin_final |=> !strobe) else $error("results past the last bin");

  a_bin_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.bin_final |=>
      strobe && result.bin_number == 6'($past(result.bin_number) + 6'd1))
    else $error("bins out of order");

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    upd_final |=> strobe && result.bin_number == 6'd0)
    else $error("burst does not start at bin zero");

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !accept) else $error("light taken during result burst");
`endif

endmodule

// ===== tb/tb_depth_bin_light_range_builder_top.sv =====
// testbench for the depth bin light range builder: directed and random lights checked against bin ranges
`timescale 1ns / 1ps

module tb_depth_bin_light_range_builder_top;

  localparam int NUM_BINS = 64;
  localparam int MAX_LIGHTS = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dbl_pkg::item_t item = '0;
  logic strobe;
  dbl_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  depth_bin_light_range_builder_top #(
    .NUM_BINS(NUM_BINS),
    .MAX_LIGHTS(MAX_LIGHTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted frame state
  logic [15:0] empty_marker;
  logic [15:0] bin_first_min [NUM_BINS];
  logic [15:0] bin_last_max [NUM_BINS];
  int unsigned frame_light_count;
  bit frame_overflow;

  dbl_pkg::item_t lights_pending [$];
  dbl_pkg::result_t bin_results_due [$];
  int error_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  int sweep_near = 0;
  int cycle_count = 0;

  function automatic longint depth_bin(logic signed [23:0] z, bit round_up);
    longint p;
    if (z <= 0) return 0;
    p = longint'(z) * NUM_BINS;
    if (round_up) p += 65535;
    return p >>> 16;
  endfunction

  function automatic void clear_frame();
    for (int b = 0; b < NUM_BINS; b++) begin
      bin_first_min[b] = empty_marker;
      bin_last_max[b] = '0;
    end
    frame_light_count = 0;
    frame_overflow = 1'b0;
  endfunction

  function automatic void take_light(dbl_pkg::item_t it);
    longint lo;
    longint hi;
    logic [15:0] idx;
    dbl_pkg::result_t r;
    if (frame_light_count >= MAX_LIGHTS) begin
      frame_overflow = 1'b1;
    end else begin
      idx = 16'(frame_light_count);
      frame_light_count++;
      if (!($signed(it.depth_near) < 0 && $signed(it.depth_far) < 0)) begin
        lo = depth_bin(it.depth_near, 1'b0);
        hi = depth_bin(it.depth_far, 1'b1);
        for (int b = 0; b < NUM_BINS; b++) begin
          if (b >= lo && b <= hi) begin
            if (idx < bin_first_min[b]) bin_first_min[b] = idx;
            if (idx > bin_last_max[b]) bin_last_max[b] = idx;
          end
        end
      end
    end
    if (it.final_light) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        r.bin_number = 6'(b);
        r.first_light = bin_first_min[b];
        r.last_light_index = bin_last_max[b];
        r.overflow = frame_overflow;
        r.bin_final = (b == NUM_BINS - 1);
        bin_results_due = {bin_results_due, r};
      end
      clear_frame();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // driver: one transfer per accepting edge
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_light(item);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (lights_pending.size() > 0) begin
          item <= lights_pending.pop_front();
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    dbl_pkg::result_t want;
    if (!rst && strobe) begin
      if (bin_results_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, result);
        error_count++;
      end else begin
        want = bin_results_due.pop_front();
        check_field("bin_number", want.bin_number, result.bin_number);
        check_field("first_light", want.first_light, result.first_light);
        check_field("last_light_index", want.last_light_index, result.last_light_index);
        check_field("overflow", want.overflow, result.overflow);
        check_field("bin_final", want.bin_final, result.bin_final);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[depth_bin_light_range_builder_top] ERROR");
      $finish;
    end
  end

  function automatic void push_light(int near_z, int far_z, bit fin);
    dbl_pkg::item_t it;
    it.depth_near = 24'(near_z);
    it.depth_far = 24'(far_z);
    it.final_light = fin;
    lights_pending = {lights_pending, it};
  endfunction

  function automatic dbl_pkg::item_t random_light(int step_max);
    dbl_pkg::item_t it;
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) begin
      sweep_near += $urandom_range(0, step_max);
      it.depth_near = 24'(sweep_near);
      if ($urandom_range(0, 3) == 0)
        it.depth_far = 24'(sweep_near + $urandom_range(0, 70000));
      else
        it.depth_far = 24'(sweep_near + $urandom_range(0, 4000));
    end else if (k < 88) begin
      it.depth_near = 24'($urandom);
      it.depth_far = 24'($urandom);
    end else if (k < 94) begin
      it.depth_near = 24'(0 - $urandom_range(1, 8388608));
      it.depth_far = 24'(0 - $urandom_range(1, 8388608));
    end else begin
      k = $urandom_range(0, 70000);
      it.depth_near = 24'(k);
      it.depth_far = 24'(k - $urandom_range(1, 40000));
    end
    it.final_light = 1'b0;
    return it;
  endfunction

  function automatic void queue_frame(int n);
    dbl_pkg::item_t it;
    int step_max;
    sweep_near = $urandom_range(0, 3000);
    step_max = 65536 / n + 1;
    for (int i = 0; i < n; i++) begin
      it = random_light(step_max);
      it.final_light = (i == n - 1);
      lights_pending = {lights_pending, it};
    end
  endfunction

  task automatic wait_idle();
    while (lights_pending.size() != 0 || start || bin_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_marker(input logic [15:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    empty_marker = v;
  endtask

  initial begin
    int lights_made;
    int phase;
    int n;
    logic [15:0] mk;
    empty_marker = dbl_pkg::MARKER_RESET;
    clear_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frame: edges of the depth range, skipped and reversed lights
    push_light(0, 0, 1'b0);
    push_light(-1, -1, 1'b0);
    push_light(-8388608, 8388607, 1'b0);
    push_light(8388607, 8388607, 1'b0);
    push_light(65536, 65536, 1'b0);
    push_light(64512, 65536, 1'b0);
    push_light(40000, 10000, 1'b0);
    push_light(-5, 1, 1'b0);
    push_light(1024, 1024, 1'b0);
    push_light(1023, 1025, 1'b0);
    push_light(-8388608, -8388608, 1'b0);
    push_light(20000, 30000, 1'b1);
    // single light frames, the first two with no covered bin
    push_light(24'h400000, -1, 1'b1);
    push_light(-300, -70000, 1'b1);
    push_light(5000, 5000, 1'b1);
    lights_made = 0;

    phase = 0;
    while (lights_made < 345) begin
      case (phase)
        0: mk = 16'hffff;
        1: mk = 16'h0000;
        2: mk = dbl_pkg::MARKER_RESET;
        default: begin
          if ($urandom_range(0, 1) == 0) mk = 16'($urandom_range(0, 300));
          else mk = 16'($urandom);
        end
      endcase
      write_marker(mk);
      for (int f = $urandom_range(2, 4); f > 0; f--) begin
        if (phase == 1 && f == 1)
          n = MAX_LIGHTS + $urandom_range(1, 5);
        else if ($urandom_range(0, 4) == 0)
          n = $urandom_range(13, 30);
        else
          n = $urandom_range(1, 12);
        queue_frame(n);
        lights_made += n;
      end
      phase++;
    end

    wait_idle();
    repeat (NUM_BINS + 16) @(negedge clk);
    if (error_count == 0) begin
      $display("[depth_bin_light_range_builder_top] OK");
    end else begin
      $display("[depth_bin_light_range_builder_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dbl_pkg.sv
sv/dbl_cell.sv
sv/dbl_front.sv
sv/depth_bin_light_range_builder_top.sv
tb/tb_depth_bin_light_range_builder_top.sv
